### rtl/core/dba_pkg.sv
// Shared constants, types and codes of the disk block allocator.
package dba_pkg;

  // Map geometry. Block numbers are 14 bits wide, so at most 2^14 blocks are mapped.
  localparam int NUM_BLOCKS = 16384;
  localparam int ID_W       = 14;
  localparam int ID_SPAN    = 1 << ID_W;
  localparam int MAP_BLOCKS = (NUM_BLOCKS < ID_SPAN) ? NUM_BLOCKS : ID_SPAN;
  localparam int WORD_W     = (MAP_BLOCKS < 64) ? 8 : 64;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int NUM_WORDS  = (MAP_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam logic [ID_W-1:0] TOP_BLOCK = ID_W'(MAP_BLOCKS - 1);

  // Freed-block queue.
  localparam int FIFO_DEPTH = 16384;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = FIFO_AW + 1;

  // Configuration port.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 14;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_DATA  = 1'b1;
  localparam logic [CFG_W-1:0] FIRST_DATA_RESET = 14'd64;
  localparam logic [CFG_W-1:0] LAST_DATA_RESET  = 14'd16383;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_FIFO_RD,
    ST_FIFO_DATA,
    ST_FIFO_MARK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DONE
  } state_t;

  // Source of the bitmap read address.
  typedef enum logic [1:0] {
    MRD_FIFO,
    MRD_CUR,
    MRD_FIRST,
    MRD_NEXT
  } map_rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        clr_wr;
    logic        take;
    logic        fifo_pop;
    logic        fifo_to_id;
    logic        map_rd;
    map_rd_sel_t map_rd_sel;
    logic        set_cur;
    logic        free_cur;
    logic        scan_hit;
    logic        res_zero;
    logic        out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic fifo_empty;
    logic range_empty;
    logic in_range;
    logic bit_set;
    logic found;
    logic at_last;
    logic out_free;
  } sts_t;

endpackage

### rtl/core/dba_req_if.sv
// Request channel: valid, ready and the request payload.
interface dba_req_if;
  import dba_pkg::*;

  logic            valid;
  logic            ready;
  logic            kind;
  logic [ID_W-1:0] blk_num;

  modport source (output valid, output kind, output blk_num, input ready);
  modport sink (input valid, input kind, input blk_num, output ready);
endinterface

### rtl/core/dba_res_if.sv
// Result channel: valid, ready and the result payload.
interface dba_res_if;
  import dba_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] granted_block;
  logic            from_fifo;
  logic            released;

  modport source (output valid, output granted_block, output from_fifo, output released,
                  input ready);
  modport sink (input valid, input granted_block, input from_fifo, input released,
                output ready);
endinterface

### rtl/core/dba_ctrl.sv
// Controller state machine of the disk block allocator.
module dba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dba_pkg::sts_t sts,
  output dba_pkg::cmd_t cmd
);
  import dba_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (sts.is_free) state_next = ST_FREE_RD;
        else if (sts.fifo_empty) state_next = ST_SCAN_RD;
        else state_next = ST_FIFO_RD;
      end
      ST_FREE_RD: begin
        state_next = sts.in_range ? ST_FREE_CHK : ST_DONE;
      end
      ST_FREE_CHK:  state_next = ST_DONE;
      ST_FIFO_RD:   state_next = ST_FIFO_DATA;
      ST_FIFO_DATA: state_next = ST_FIFO_MARK;
      ST_FIFO_MARK: state_next = ST_DONE;
      ST_SCAN_RD: begin
        state_next = sts.range_empty ? ST_DONE : ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (sts.found || sts.at_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd            = '0;
    cmd.map_rd_sel = MRD_CUR;
    in_ready       = 1'b0;
    unique case (state)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_DECODE: ;
      ST_FREE_RD: begin
        if (sts.in_range) begin
          cmd.map_rd     = 1'b1;
          cmd.map_rd_sel = MRD_CUR;
        end else begin
          cmd.res_zero = 1'b1;
        end
      end
      ST_FREE_CHK: begin
        if (sts.bit_set) cmd.free_cur = 1'b1;
        else cmd.res_zero = 1'b1;
      end
      ST_FIFO_RD: cmd.fifo_pop = 1'b1;
      ST_FIFO_DATA: begin
        cmd.fifo_to_id = 1'b1;
        cmd.map_rd     = 1'b1;
        cmd.map_rd_sel = MRD_FIFO;
      end
      ST_FIFO_MARK: cmd.set_cur = 1'b1;
      ST_SCAN_RD: begin
        if (sts.range_empty) begin
          cmd.res_zero = 1'b1;
        end else begin
          cmd.map_rd     = 1'b1;
          cmd.map_rd_sel = MRD_FIRST;
        end
      end
      ST_SCAN_CHK: begin
        if (sts.found) begin
          cmd.scan_hit = 1'b1;
        end else if (sts.at_last) begin
          cmd.res_zero = 1'b1;
        end else begin
          // Fetch the next word; it is examined in the following cycle.
          cmd.map_rd     = 1'b1;
          cmd.map_rd_sel = MRD_NEXT;
        end
      end
      ST_DONE: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

  // An accepted transaction is decoded in the next cycle.
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> state == ST_DECODE)
    else $error("accepted request not decoded");

  // A result is handed over only when the output slot is free, then the block goes idle.
  assert property (@(posedge clk) disable iff (rst) cmd.out_load |=> state == ST_IDLE)
    else $error("result load did not return to idle");

  // The bitmap is never read while the clearing pass writes it.
  assert property (@(posedge clk) disable iff (rst) !(cmd.clr_wr && cmd.map_rd))
    else $error("bitmap read during clearing pass");
endmodule

### rtl/core/dba_datapath.sv
// Datapath: range registers, in-use bitmap, freed-block queue and result registers.
module dba_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  dba_pkg::cmd_t                 cmd,
  output dba_pkg::sts_t                 sts,
  input  logic                          cfg_we,
  input  logic [dba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dba_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_kind,
  input  logic [dba_pkg::ID_W-1:0]      in_blk_num,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dba_pkg::ID_W-1:0]      out_granted_block,
  output logic                          out_from_fifo,
  output logic                          out_released
);
  import dba_pkg::*;

  function automatic logic [WADDR_W-1:0] id_word(input logic [ID_W-1:0] id);
    id_word = WADDR_W'(id >> BIT_W);
  endfunction

  logic [CFG_W-1:0]   first_data_block;
  logic [CFG_W-1:0]   last_data_block;
  logic [ID_W-1:0]    range_lo;
  logic [ID_W-1:0]    range_hi;

  logic               cur_kind;
  logic [ID_W-1:0]    cur_id;

  logic [ID_W-1:0]    fifo_mem [FIFO_DEPTH];
  logic [ID_W-1:0]    fifo_rd_data;
  logic [FIFO_AW-1:0] fifo_head;
  logic [FIFO_AW-1:0] fifo_tail;
  logic [CNT_W-1:0]   fifo_count;
  logic               fifo_push;

  logic [WORD_W-1:0]  map_mem [NUM_WORDS];
  logic [WORD_W-1:0]  map_rd_data;
  logic [WADDR_W-1:0] map_raddr;
  logic [WADDR_W-1:0] map_waddr;
  logic [WORD_W-1:0]  map_wdata;
  logic               map_we;
  logic [WADDR_W-1:0] clr_ptr;
  logic [WADDR_W-1:0] scan_ptr;

  logic [WORD_W-1:0]  cur_mask;
  logic [WORD_W-1:0]  low_mask;
  logic [WORD_W-1:0]  high_mask;
  logic [WORD_W-1:0]  cand;
  logic [WORD_W-1:0]  hit_mask;
  logic [BIT_W-1:0]   hit_bit;

  logic [ID_W-1:0]    res_block;
  logic               res_fifo;
  logic               res_rel;

  // Range registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_data_block <= FIRST_DATA_RESET;
      last_data_block  <= LAST_DATA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_DATA: first_data_block <= cfg_data;
        CFG_LAST_DATA:  last_data_block  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Block zero means "none", so the low bound is at least one; the high bound stops at
  // the last mapped block.
  assign range_lo = (first_data_block == '0) ? ID_W'(1) : first_data_block;
  assign range_hi = (last_data_block < TOP_BLOCK) ? last_data_block : TOP_BLOCK;

  // Request held while it is worked on; a queue pop replaces the block number.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_kind <= in_kind;
      cur_id   <= in_blk_num;
    end else if (cmd.fifo_to_id) begin
      cur_id <= fifo_rd_data;
    end
  end

  // Freed-block queue storage with registered read.
  assign fifo_push = cmd.free_cur && (fifo_count != CNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (fifo_push) fifo_mem[fifo_tail] <= cur_id;
    if (cmd.fifo_pop) fifo_rd_data <= fifo_mem[fifo_head];
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_head  <= '0;
      fifo_tail  <= '0;
      fifo_count <= '0;
    end else begin
      if (fifo_push) fifo_tail <= fifo_tail + FIFO_AW'(1);
      if (cmd.fifo_pop) fifo_head <= fifo_head + FIFO_AW'(1);
      if (fifo_push && !cmd.fifo_pop) fifo_count <= fifo_count + CNT_W'(1);
      else if (cmd.fifo_pop && !fifo_push) fifo_count <= fifo_count - CNT_W'(1);
    end
  end

  // Clearing pass pointer, one bitmap word per cycle after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clr_wr) begin
      clr_ptr <= clr_ptr + WADDR_W'(1);
    end
  end

  // Bitmap read address.
  always_comb begin
    case (cmd.map_rd_sel)
      MRD_FIFO:  map_raddr = id_word(fifo_rd_data);
      MRD_CUR:   map_raddr = id_word(cur_id);
      MRD_FIRST: map_raddr = id_word(range_lo);
      MRD_NEXT:  map_raddr = scan_ptr + WADDR_W'(1);
      default:   map_raddr = id_word(cur_id);
    endcase
  end

  // Scan pointer follows every scan read.
  always_ff @(posedge clk) begin
    if (cmd.map_rd && (cmd.map_rd_sel == MRD_FIRST || cmd.map_rd_sel == MRD_NEXT)) begin
      scan_ptr <= map_raddr;
    end
  end

  // First-fit search inside the current word, limited to the data range.
  assign cur_mask  = WORD_W'(1) << cur_id[BIT_W-1:0];
  assign low_mask  = (scan_ptr == id_word(range_lo)) ? ({WORD_W{1'b1}} << range_lo[BIT_W-1:0])
                                                    : {WORD_W{1'b1}};
  assign high_mask = (scan_ptr == id_word(range_hi)) ? ({WORD_W{1'b1}} >> (~range_hi[BIT_W-1:0]))
                                                    : {WORD_W{1'b1}};
  assign cand      = ~map_rd_data & low_mask & high_mask;
  assign hit_mask  = cand & ~(cand - WORD_W'(1));

  always_comb begin
    hit_bit = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (cand[j]) hit_bit = BIT_W'(j);
    end
  end

  // Bitmap write port: clearing pass or read-modify-write of the word just read.
  assign map_we = cmd.clr_wr || cmd.set_cur || cmd.free_cur || cmd.scan_hit;

  always_comb begin
    if (cmd.clr_wr) begin
      map_waddr = clr_ptr;
      map_wdata = '0;
    end else if (cmd.scan_hit) begin
      map_waddr = scan_ptr;
      map_wdata = map_rd_data | hit_mask;
    end else if (cmd.free_cur) begin
      map_waddr = id_word(cur_id);
      map_wdata = map_rd_data & ~cur_mask;
    end else begin
      map_waddr = id_word(cur_id);
      map_wdata = map_rd_data | cur_mask;
    end
  end

  // Bitmap storage with registered read.
  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (cmd.map_rd) map_rd_data <= map_mem[map_raddr];
  end

  // Result of the current request.
  always_ff @(posedge clk) begin
    if (cmd.set_cur) begin
      res_block <= cur_id;
      res_fifo  <= 1'b1;
      res_rel   <= 1'b0;
    end else if (cmd.scan_hit) begin
      res_block <= ID_W'({scan_ptr, hit_bit});
      res_fifo  <= 1'b0;
      res_rel   <= 1'b0;
    end else if (cmd.free_cur) begin
      res_block <= '0;
      res_fifo  <= 1'b0;
      res_rel   <= 1'b1;
    end else if (cmd.res_zero) begin
      res_block <= '0;
      res_fifo  <= 1'b0;
      res_rel   <= 1'b0;
    end
  end

  // Output register; it holds a result until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_granted_block <= res_block;
      out_from_fifo     <= res_fifo;
      out_released      <= res_rel;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.clr_last    = (clr_ptr == WADDR_W'(NUM_WORDS - 1));
    sts.is_free     = (cur_kind == KIND_FREE);
    sts.fifo_empty  = (fifo_count == '0);
    sts.range_empty = (range_lo > range_hi);
    sts.in_range    = (cur_id >= range_lo) && (cur_id <= range_hi);
    sts.bit_set     = map_rd_data[cur_id[BIT_W-1:0]];
    sts.found       = |cand;
    sts.at_last     = (scan_ptr == id_word(range_hi));
    sts.out_free    = !out_valid || out_ready;
  end

  // The queue is never popped empty.
  assert property (@(posedge clk) disable iff (rst) cmd.fifo_pop |-> fifo_count != '0)
    else $error("freed-block queue popped while empty");

  // A pending result is never overwritten.
  assert property (@(posedge clk) disable iff (rst) cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // At most one source drives the bitmap write port.
  assert property (@(posedge clk) disable iff (rst)
                   $onehot0({cmd.clr_wr, cmd.set_cur, cmd.free_cur, cmd.scan_hit}))
    else $error("bitmap write port conflict");

  // The fill count tracks a push by one.
  assert property (@(posedge clk) disable iff (rst)
                   (fifo_push && !cmd.fifo_pop) |=> fifo_count == $past(fifo_count) + CNT_W'(1))
    else $error("queue count did not follow a push");
endmodule

### rtl/core/disk_block_allocator.sv
// Top level of the disk block allocator: controller, datapath and channel hookup.
//
//   channel  direction  handshake      payload
//   req      in         valid/ready    kind, blk_num
//   res      out        valid/ready    granted_block, from_fifo, released
//   cfg      in         cfg_we         cfg_index, cfg_data (no read-back)
//
// A free reads the bitmap word and clears the block's bit, but skips the bitmap when the
// block number lies outside the data range; an allocate from the freed-block queue pops
// the queue, reads the word and marks the block; an allocate by scan reads 64-bit bitmap
// words from the low bound (1 to 256 words, none for an empty range) until one has a free bit.
// After reset a clearing pass zeroes all 256 bitmap words, one word a cycle, while no
// request is taken. A finished result waits in the output register; the next request is
// taken meanwhile and holds in its last step only while that register is still full.
module disk_block_allocator (
  input  logic                          clk,
  input  logic                          rst,
  dba_req_if.sink                       req,
  dba_res_if.source                     res,
  input  logic                          cfg_we,
  input  logic [dba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dba_pkg::CFG_W-1:0]     cfg_data
);
  import dba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing of each request.
  dba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and arithmetic.
  dba_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_kind           (req.kind),
    .in_blk_num        (req.blk_num),
    .out_valid         (res.valid),
    .out_ready         (res.ready),
    .out_granted_block (res.granted_block),
    .out_from_fifo     (res.from_fifo),
    .out_released      (res.released)
  );
endmodule

### tb/sv/tb.sv
// Self-checking testbench of the disk block allocator: request driver, result monitor, scoreboard.
`timescale 1ns / 100ps

module tb;
  import dba_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_GAP   = 8;
  localparam int DRAIN_TAIL  = 300;
  localparam int PRINT_LIMIT = 100;

  // One request and the result that it should produce.
  typedef struct {
    logic            kind;
    logic [ID_W-1:0] blk_num;
  } request_t;

  typedef struct packed {
    logic [ID_W-1:0] granted_block;
    logic            from_fifo;
    logic            released;
  } grant_t;

  logic clk;
  logic rst = 1'b1;

  // Values driven into the block; the initializers make them known from time zero.
  logic                 req_valid    = 1'b0;
  logic                 req_kind     = 1'b0;
  logic [ID_W-1:0]      req_blk_num  = '0;
  logic                 res_ready    = 1'b0;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;

  dba_req_if req_ch ();
  dba_res_if res_ch ();

  assign req_ch.valid   = req_valid;
  assign req_ch.kind    = req_kind;
  assign req_ch.blk_num = req_blk_num;
  assign res_ch.ready   = res_ready;

  disk_block_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Stimulus bookkeeping.
  request_t        pending_requests[$];
  grant_t          expected_grants[$];
  logic [ID_W-1:0] held_blocks[$];
  int              queued_count   = 0;
  int              accepted_count = 0;
  int              error_count    = 0;
  int              range_settings = 0;
  bit              quiet          = 1'b0;
  logic            req_hs         = 1'b0;
  int              req_gap        = 0;
  int              res_stall      = 0;

  // Predictor state: mirror of the range registers, the in-use map and the freed-block queue.
  logic [CFG_W-1:0] range_first = FIRST_DATA_RESET;
  logic [CFG_W-1:0] range_last  = LAST_DATA_RESET;
  bit               block_used[MAP_BLOCKS];
  logic [ID_W-1:0]  freed_blocks[$];

  // Coverage tallies for the summary.
  int grants_from_queue = 0;
  int grants_by_scan    = 0;
  int grants_none       = 0;
  int releases          = 0;
  int frees_ignored     = 0;

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  // Watchdog: a run that does not finish within the cycle budget fails.
  initial begin : watchdog
    int n;
    for (n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Apply one accepted request to the predictor state and queue the result it produces.
  task automatic predict_grant(input logic kind, input logic [ID_W-1:0] id);
    grant_t          g;
    logic [ID_W-1:0] lo;
    logic [ID_W-1:0] hi;
    int              b;
    g  = '0;
    lo = (range_first == '0) ? ID_W'(1) : range_first;
    hi = (range_last < TOP_BLOCK) ? range_last : TOP_BLOCK;
    if (kind == KIND_ALLOC) begin
      if (freed_blocks.size() != 0) begin
        // A queued block is handed out even if the range has moved since it was freed.
        g.granted_block = freed_blocks.pop_front();
        g.from_fifo = 1'b1;
        block_used[g.granted_block] = 1'b1;
        grants_from_queue++;
      end else begin
        for (b = int'(lo); b <= int'(hi); b++) begin
          if (!block_used[b]) begin
            block_used[b] = 1'b1;
            g.granted_block = ID_W'(b);
            break;
          end
        end
        if (g.granted_block == '0) grants_none++;
        else grants_by_scan++;
      end
      if (g.granted_block != '0) begin
        held_blocks.push_back(g.granted_block);
        if (held_blocks.size() > 256) void'(held_blocks.pop_front());
      end
    end else if (id >= lo && id <= hi && block_used[id]) begin
      block_used[id] = 1'b0;
      if (freed_blocks.size() < FIFO_DEPTH) freed_blocks.push_back(id);
      g.released = 1'b1;
      releases++;
    end else begin
      frees_ignored++;
    end
    expected_grants.push_back(g);
  endtask

  // Request driver: one transaction at a time, with random gaps outside the quiet stretch.
  always @(negedge clk) begin : drive_requests
    request_t nxt;
    if (!rst) begin
      if (req_valid && !req_hs) begin
        // The current transaction has not been taken yet; hold it.
      end else if (req_gap > 0) begin
        req_gap   <= req_gap - 1;
        req_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        if (!quiet && $urandom_range(7) == 0) begin
          req_gap   <= int'($urandom_range(10, 1)) - 1;
          req_valid <= 1'b0;
        end else begin
          nxt = pending_requests.pop_front();
          req_valid   <= 1'b1;
          req_kind    <= nxt.kind;
          req_blk_num <= nxt.blk_num;
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result receiver: stalls in random bursts outside the quiet stretch.
  always @(negedge clk) begin : drive_ready
    if (!rst) begin
      if (res_stall > 0) begin
        res_stall <= res_stall - 1;
        res_ready <= 1'b0;
      end else if (!quiet && $urandom_range(5) == 0) begin
        res_stall <= int'($urandom_range(9, 0));
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Monitor: track register writes, check results against the oldest expectation,
  // then predict the request taken at this edge.
  always @(posedge clk) begin : monitor
    grant_t want;
    req_hs <= !rst && req_valid && req_ch.ready;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST_DATA: range_first = cfg_data;
          CFG_LAST_DATA:  range_last  = cfg_data;
          default: ;
        endcase
      end
      if (res_ch.valid && res_ready) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("result with no request pending, granted_block",
                          int'(res_ch.granted_block), -1);
        end else begin
          want = expected_grants.pop_front();
          if (res_ch.granted_block !== want.granted_block)
            report_mismatch("granted_block", int'(res_ch.granted_block),
                            int'(want.granted_block));
          if (res_ch.from_fifo !== want.from_fifo)
            report_mismatch("from_fifo", int'(res_ch.from_fifo), int'(want.from_fifo));
          if (res_ch.released !== want.released)
            report_mismatch("released", int'(res_ch.released), int'(want.released));
        end
      end
      if (req_valid && req_ch.ready) begin
        predict_grant(req_kind, req_blk_num);
        accepted_count++;
      end
    end
  end

  task automatic send_request(input logic kind, input int id);
    request_t r;
    r.kind    = kind;
    r.blk_num = ID_W'(id);
    pending_requests.push_back(r);
    queued_count++;
  endtask

  // Wait until every queued request has been taken and answered, then for the given extra cycles.
  task automatic settle(input int extra);
    while (accepted_count != queued_count || expected_grants.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_range(input int first, input int last);
    settle(PHASE_GAP);
    write_reg(CFG_FIRST_DATA, first);
    write_reg(CFG_LAST_DATA, last);
    range_settings++;
  endtask

  // Mostly allocations and frees of recently granted blocks, with some noise.
  function automatic request_t random_request(input int lo, input int hi);
    request_t r;
    int       pick;
    pick      = int'($urandom_range(99));
    r.kind    = KIND_FREE;
    r.blk_num = ID_W'($urandom());
    if (pick < 50) begin
      r.kind = KIND_ALLOC;
    end else if (pick < 80 && held_blocks.size() != 0) begin
      r.blk_num = held_blocks[$urandom_range(held_blocks.size() - 1)];
    end else if (pick < 92) begin
      r.blk_num = ID_W'($urandom_range(hi, lo));
    end else if (pick < 96) begin
      r.blk_num = ID_W'(($urandom_range(1) != 0) ? lo - 1 : hi + 1);
    end
    return r;
  endfunction

  task automatic random_phase(input int first, input int last, input int count);
    int       n;
    int       lo;
    request_t r;
    set_range(first, last);
    lo = (first == 0) ? 1 : first;
    for (n = 0; n < count; n++) begin
      // Keep the queue short so that frees pick from fresh grants.
      while (pending_requests.size() >= 4) @(negedge clk);
      r = random_request(lo, last);
      pending_requests.push_back(r);
      queued_count++;
    end
  endtask

  initial begin : stimulus
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Reset range 64..16383: scan grants, a release, a double free, out-of-range frees, a queue grant.
    send_request(KIND_ALLOC, 0);
    send_request(KIND_ALLOC, 16383);
    send_request(KIND_ALLOC, 0);
    send_request(KIND_FREE, 65);
    send_request(KIND_FREE, 65);
    send_request(KIND_FREE, 0);
    send_request(KIND_FREE, 63);
    send_request(KIND_FREE, 16383);
    send_request(KIND_ALLOC, 0);
    send_request(KIND_ALLOC, 0);

    // Lower bound of zero acts as one; a three-block range runs dry.
    set_range(0, 3);
    send_request(KIND_ALLOC, 0);
    send_request(KIND_ALLOC, 0);
    send_request(KIND_ALLOC, 0);
    send_request(KIND_ALLOC, 0);
    send_request(KIND_FREE, 2);
    send_request(KIND_FREE, 0);
    send_request(KIND_ALLOC, 0);
    send_request(KIND_FREE, 1);

    // Single top block; block 1 is still queued and is handed out although out of range.
    set_range(16383, 16383);
    send_request(KIND_ALLOC, 0);
    send_request(KIND_ALLOC, 0);
    send_request(KIND_ALLOC, 0);
    send_request(KIND_FREE, 16383);
    send_request(KIND_FREE, 16382);

    // Empty range: the queued block still goes out, then nothing is granted or freed.
    set_range(300, 200);
    send_request(KIND_ALLOC, 0);
    send_request(KIND_ALLOC, 0);
    send_request(KIND_FREE, 64);

    // Random traffic over a series of ranges; the last one runs without idling.
    random_phase(64, 127, 300);
    random_phase(1, 40, 300);
    random_phase(16300, 16383, 300);
    random_phase(0, 16383, 250);
    random_phase(500, 499, 50);
    settle(PHASE_GAP);
    quiet = 1'b1;
    random_phase(200, 230, 300);

    settle(DRAIN_TAIL);
    $display("Checked %0d requests over %0d range settings besides the reset one.",
             accepted_count, range_settings);
    $display("Queue grants %0d, scan grants %0d, exhausted %0d, releases %0d, ignored frees %0d.",
             grants_from_queue, grants_by_scan, grants_none, releases, frees_ignored);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
